@@ hdl/block_average_pixelate_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the block average pixelate core
// Shared property wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_PIXELATE_CORE_MACROS_SVH
`define BLOCK_AVERAGE_PIXELATE_CORE_MACROS_SVH

// Same-cycle implication
`define BAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bap_pkg.sv @@
// ----------------------------------------------------------------------------
// bap_pkg
// Shared constants and types of the block average pixelate core.
// ----------------------------------------------------------------------------
package bap_pkg;
    localparam int SUM_W      = 20;
    localparam int CNT_W      = 13;
    localparam int POS_W      = 12;
    localparam int OFS_W      = 6;
    localparam int BS_W       = 7;
    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 4;
    localparam int NUM_LANES  = 5;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_BLOCK  = 64;
    localparam int ADDR_W     = 4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLOCK  = 2'd2;

    typedef logic [NUM_LANES-1:0][SUM_W-1:0] t_lanes;
    typedef logic [NUM_LANES-1:0][CNT_W-1:0] t_dens;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_DIV,
        S_OUT
    } t_state;
endpackage

@@ hdl/block_average_pixelate_core.sv @@
// A block-closing pixel beat passes through the sum RAM read, the
// read-modify-write, 20 divider steps and the result beat.
// A new pixel is taken only once the last one is done, for a closing pixel
// only after its result beat is accepted; the shared radix-2 divider takes most of that.
// Reset: synchronous active-low; position counters clear, registers take
// 640 x 480 with 8-pixel blocks; the sum RAM is not cleared.
// ----------------------------------------------------------------------------
// block_average_pixelate_core
// Streams RGBA pixels, keeps per-block-column channel sums in one RAM and
// emits the truncated channel means of each finished block.
// ----------------------------------------------------------------------------
module block_average_pixelate_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input: tdata = blue[7:0], green[15:8], red[23:16], alpha[31:24]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,
    // tuser = frame_start[0]
    input  logic        i_s_tuser,
    // block result: tdata = block_col[11:0], block_row[23:12], avg_blue[31:24],
    // avg_green[39:32], avg_red[47:40], avg_alpha[55:48]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,
    // tlast = frame_done
    output logic        o_m_tlast,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bap_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bap_pkg::*;

    localparam int RAM_W = NUM_CH * SUM_W;

    t_state r_state, n_state;

    // configuration registers
    logic [CNT_W-1:0] r_width, r_height;
    logic [BS_W-1:0]  r_block;

    // position counters
    logic [POS_W-1:0] r_px, r_py, r_cb;
    logic [OFS_W-1:0] r_ox, r_oy;

    // latched beat and its decisions
    logic [NUM_CH*PIX_W-1:0] r_pix;
    logic [POS_W-1:0]        r_col, r_row_py;
    logic                    r_first, r_emit, r_fend;
    logic [CNT_W-1:0]        r_count;
    logic [BS_W-1:0]         r_bs;

    // result register
    logic [55:0] r_tdata;
    logic        r_tlast;

    // effective (clamped) configuration
    logic [CNT_W-1:0] w_eff, h_eff, wm1, hm1;
    logic [BS_W-1:0]  bs_eff, bsm1;

    always_comb begin
        if (r_width == '0) w_eff = CNT_W'(1);
        else if (r_width > CNT_W'(MAX_WIDTH)) w_eff = CNT_W'(MAX_WIDTH);
        else w_eff = r_width;
        if (r_height == '0) h_eff = CNT_W'(1);
        else if (r_height > CNT_W'(MAX_HEIGHT)) h_eff = CNT_W'(MAX_HEIGHT);
        else h_eff = r_height;
        if (r_block == '0) bs_eff = BS_W'(1);
        else if (r_block > BS_W'(MAX_BLOCK)) bs_eff = BS_W'(MAX_BLOCK);
        else bs_eff = r_block;
        wm1  = w_eff - 1'b1;
        hm1  = h_eff - 1'b1;
        bsm1 = bs_eff - 1'b1;
    end

    // APB: pready is tied high, so a write completes in its access cycle
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_BLOCK:  prdata = 32'(r_block);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CNT_W'(640);
            r_height <= CNT_W'(480);
            r_block  <= BS_W'(8);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[CNT_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CNT_W-1:0];
                REG_BLOCK:  r_block  <= pwdata[BS_W-1:0];
                default:    ;
            endcase
        end
    end

    // Beat decode: frame_start forces the counters to the top left first
    logic             s_acc;
    logic [POS_W-1:0] px, py, cb;
    logic [OFS_W-1:0] ox, oy;
    logic             line_end, last_line, bx_end, by_end;
    logic [POS_W-1:0] n_px, n_py, n_cb;
    logic [OFS_W-1:0] n_ox, n_oy;

    assign s_acc = i_s_tvalid && o_s_tready;

    always_comb begin
        px = i_s_tuser ? '0 : r_px;
        py = i_s_tuser ? '0 : r_py;
        cb = i_s_tuser ? '0 : r_cb;
        ox = i_s_tuser ? '0 : r_ox;
        oy = i_s_tuser ? '0 : r_oy;

        line_end  = {1'b0, px} >= wm1;
        last_line = {1'b0, py} >= hm1;
        bx_end    = line_end || ({1'b0, ox} >= bsm1);
        by_end    = last_line || ({1'b0, oy} >= bsm1);

        n_px = px; n_py = py; n_cb = cb; n_ox = ox; n_oy = oy;
        if (line_end) begin
            n_px = '0;
            n_ox = '0;
            n_cb = '0;
            if (last_line) begin
                n_py = '0;
                n_oy = '0;
            end else begin
                n_py = py + 1'b1;
                n_oy = ({1'b0, oy} >= bsm1) ? '0 : oy + 1'b1;
            end
        end else begin
            n_px = px + 1'b1;
            if ({1'b0, ox} >= bsm1) begin
                n_ox = '0;
                n_cb = cb + 1'b1;
            end else begin
                n_ox = ox + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_cb <= '0;
            r_ox <= '0;
            r_oy <= '0;
        end else if (s_acc) begin
            r_px <= n_px;
            r_py <= n_py;
            r_cb <= n_cb;
            r_ox <= n_ox;
            r_oy <= n_oy;
        end
    end

    // Hold the beat and its block decisions for the read-modify-write
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_pix    <= i_s_tdata;
            r_col    <= cb;
            r_row_py <= py;
            r_first  <= (ox == '0) && (oy == '0);
            r_emit   <= bx_end && by_end;
            r_fend   <= line_end && last_line;
            r_count  <= (CNT_W'(ox) + CNT_W'(1)) * (CNT_W'(oy) + CNT_W'(1));
            r_bs     <= bs_eff;
        end
    end

    // Sum RAM: four 20-bit channel sums per block column
    logic             ram_we;
    logic [RAM_W-1:0] ram_rdata, ram_wdata;
    t_lanes           div_num, div_quot;
    t_dens            div_den;
    logic             div_start, div_done;

    bap_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (ram_wdata),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Modify: first pixel of a block overwrites, others add with wrap
    always_comb begin
        ram_wdata = '0;
        div_num   = '0;
        div_den   = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            ram_wdata[c*SUM_W +: SUM_W] = (r_first ? '0 : ram_rdata[c*SUM_W +: SUM_W])
                                        + SUM_W'(r_pix[c*PIX_W +: PIX_W]);
            div_num[c] = ram_wdata[c*SUM_W +: SUM_W];
            div_den[c] = r_count;
        end
        div_num[NUM_CH] = SUM_W'(r_row_py);
        div_den[NUM_CH] = CNT_W'(r_bs);
    end

    bap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer: next state and handshake outputs
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) n_state = S_READ;
            end
            S_READ: n_state = S_CALC;
            S_CALC: begin
                ram_we    = 1'b1;
                div_start = r_emit;
                n_state   = r_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Result register: saturate means above 255
    logic [NUM_CH*PIX_W-1:0] avgs;
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            avgs[c*PIX_W +: PIX_W] = (div_quot[c] > SUM_W'(255)) ? 8'hFF
                                   : div_quot[c][PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_done) begin
            r_tdata <= {avgs, div_quot[NUM_CH][POS_W-1:0], r_col};
            r_tlast <= r_fend;
        end
    end

    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = r_tdata;
    assign o_m_tlast  = r_tlast;

`include "block_average_pixelate_core_macros.svh"

    `BAP_ASSERT_NOW(a_one_item, o_s_tready, !o_m_tvalid, "input ready while result pending")
    `BAP_ASSERT_NEXT(a_acc_read, s_acc, r_state == S_READ, "accepted beat did not start read")
    `BAP_ASSERT_NEXT(a_div_out, div_done && r_state == S_DIV, o_m_tvalid, "divide end gave no beat")
    `BAP_ASSERT_NOW(a_we_calc, ram_we, !o_s_tready && !o_m_tvalid, "RAM write outside update")

endmodule

@@ hdl/bap_ram.sv @@
// ----------------------------------------------------------------------------
// bap_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/bap_div.sv @@
// ----------------------------------------------------------------------------
// bap_div
// Restoring divider, one quotient bit per cycle on all lanes in parallel.
// ----------------------------------------------------------------------------
module bap_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  bap_pkg::t_lanes      i_num,
    input  bap_pkg::t_dens       i_den,
    output logic                 o_done,
    output bap_pkg::t_lanes      o_quot
);
    import bap_pkg::*;

    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    t_lanes              r_quot, n_quot;
    t_dens               r_den;
    logic [NUM_LANES-1:0][CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W:0]      trial;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        trial  = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            trial = {r_rem[l], r_quot[l][SUM_W-1]};
            n_quot[l] = {r_quot[l][SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den[l]}) begin
                trial = trial - {1'b0, r_den[l]};
                n_quot[l][0] = 1'b1;
            end
            n_rem[l] = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_busy && (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_quot = n_quot;
endmodule
